FILE: rtl/morse_keyer_with_slot_registers_top_defines.svh
// Assertion macros for the keyer top module.
`ifndef MORSE_KEYER_WITH_SLOT_REGISTERS_TOP_DEFINES_SVH
`define MORSE_KEYER_WITH_SLOT_REGISTERS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MKR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyer assertion failed");
`define MKR_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("keyer assertion failed");
`else
`define MKR_ASSERT(label, clk, rst_n, prop)
`define MKR_ASSERT_NORST(label, clk, prop)
`endif

`endif

FILE: rtl/mkr_pkg.sv
package mkr_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int GAP_UNITS  = 7;
    localparam int MAX_CODE   = 36;
    localparam int SEL_MAX    = 15;
    localparam int REG_ENABLE = NUM_SLOTS;

    localparam int SLOT_W  = 4;
    localparam int SLOT_AW = $clog2(NUM_SLOTS);
    localparam int ELEM_W  = 3;
    localparam int SUB_W   = 3;
    localparam int CODE_W  = 6;
    localparam int LEN_W   = 3;
    localparam int BITS_W  = 5;
    localparam int PHASE_W = 2;
    localparam int SEL_W   = 4;

    localparam logic [1:0] OP_STOP = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       key_on;
        logic [3:0] sending_slot;
    } t_out_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              active;
    } t_sender_status;

    // Number of elements in each character.
    function automatic logic [LEN_W-1:0] sym_len(input logic [CODE_W-1:0] code);
        logic [LEN_W-1:0] len;
        case (code) inside
            6'd0:            len = 3'd3;
            [6'd1:6'd10]:    len = 3'd5;
            6'd15, 6'd30:    len = 3'd1;
            6'd11, 6'd19, 6'd23, 6'd24:
                             len = 3'd2;
            6'd14, 6'd17, 6'd21, 6'd25, 6'd28, 6'd29, 6'd31, 6'd32, 6'd33:
                             len = 3'd3;
            6'd12, 6'd13, 6'd16, 6'd18, 6'd20, 6'd22, 6'd26, 6'd27,
            6'd34, 6'd35, 6'd36:
                             len = 3'd4;
            default:         len = 3'd3;
        endcase
        return len;
    endfunction

    // Element pattern, a set bit is a dash, first element in the top used bit.
    function automatic logic [BITS_W-1:0] sym_bits(input logic [CODE_W-1:0] code);
        logic [BITS_W-1:0] bits;
        case (code)
            6'd1:    bits = 5'h1F;
            6'd2:    bits = 5'h0F;
            6'd3:    bits = 5'h07;
            6'd4:    bits = 5'h03;
            6'd5:    bits = 5'h01;
            6'd7:    bits = 5'h10;
            6'd8:    bits = 5'h18;
            6'd9:    bits = 5'h1C;
            6'd10:   bits = 5'h1E;
            6'd11:   bits = 5'h01;
            6'd12:   bits = 5'h08;
            6'd13:   bits = 5'h0A;
            6'd14:   bits = 5'h04;
            6'd16:   bits = 5'h02;
            6'd17:   bits = 5'h06;
            6'd20:   bits = 5'h07;
            6'd21:   bits = 5'h05;
            6'd22:   bits = 5'h04;
            6'd23:   bits = 5'h03;
            6'd24:   bits = 5'h02;
            6'd25:   bits = 5'h07;
            6'd26:   bits = 5'h06;
            6'd27:   bits = 5'h0D;
            6'd28:   bits = 5'h02;
            6'd30:   bits = 5'h01;
            6'd31:   bits = 5'h01;
            6'd32:   bits = 5'h01;
            6'd33:   bits = 5'h03;
            6'd34:   bits = 5'h09;
            6'd35:   bits = 5'h0B;
            6'd36:   bits = 5'h0C;
            default: bits = 5'h00;
        endcase
        return bits;
    endfunction

endpackage

FILE: rtl/morse_keyer_with_slot_registers_top.sv
// Morse keyer with eight character slot registers.
//
// Input channel (i_in_valid, i_in_data, o_in_stall) carries one item per
// bus event or unit tick: a stop, a received byte or a Morse unit tick.
// After a stop, the first byte selects a register and the second writes
// it; registers 0 to 7 hold character codes and register 8 the enable.
// Each tick advances the sender by one Morse unit.
// Output channel (o_out_valid, o_out_data, i_out_stall) returns exactly one
// item for every accepted input item: the key level and the slot in use.
// The result sits in the output register in the cycle after acceptance.
// Throughput is one item per cycle while the receiver does not stall, set
// by the single register stage between the state update and the output.
// When the receiver stalls and the output register is full, o_in_stall is
// raised and no item is taken until the result has been delivered.
// A synchronous reset clears the slots to space, the enable and the
// sender position, and empties the output register.
`include "morse_keyer_with_slot_registers_top_defines.svh"

module morse_keyer_with_slot_registers_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mkr_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output mkr_pkg::t_out_item  o_out_data,
    input  logic                i_out_stall
);
    import mkr_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [SEL_W-1:0]   r_sel, n_sel;
    logic [CODE_W-1:0]  r_slots [NUM_SLOTS];
    logic [CODE_W-1:0]  n_slots [NUM_SLOTS];
    logic               r_enable, n_enable;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_acc;
    logic               tick;
    logic [CODE_W-1:0]  cur_code;
    logic               next_active;
    t_sender_status     status;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign tick       = in_acc && (i_in_data.operation == OP_TICK);
    assign cur_code   = r_slots[status.slot_index[SLOT_AW-1:0]];

    mkr_sender u_sender (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick),
        .i_code        (cur_code),
        .o_status      (status),
        .o_next_active (next_active)
    );

    always_comb begin
        n_phase  = r_phase;
        n_sel    = r_sel;
        n_slots  = r_slots;
        n_enable = r_enable;
        if (in_acc) begin
            case (i_in_data.operation)
                OP_STOP: begin
                    n_phase = '0;
                end
                OP_BYTE: begin
                    if (r_phase == PHASE_W'(0)) begin
                        n_sel = (i_in_data.rx_byte > 8'(SEL_MAX)) ?
                                SEL_W'(SEL_MAX) : i_in_data.rx_byte[SEL_W-1:0];
                    end else if (r_phase == PHASE_W'(1)) begin
                        if (r_sel < SEL_W'(NUM_SLOTS)) begin
                            n_slots[r_sel[SLOT_AW-1:0]] =
                                (i_in_data.rx_byte > 8'(MAX_CODE)) ?
                                '0 : i_in_data.rx_byte[CODE_W-1:0];
                        end else if (r_sel == SEL_W'(REG_ENABLE)) begin
                            n_enable = (i_in_data.rx_byte != '0);
                        end
                    end
                    if (r_phase < PHASE_W'(2)) begin
                        n_phase = r_phase + PHASE_W'(1);
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_sel       <= '0;
            r_enable    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slots[i] <= '0;
            end
        end else begin
            r_phase  <= n_phase;
            r_sel    <= n_sel;
            r_enable <= n_enable;
            r_slots  <= n_slots;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.key_on       <= next_active & n_enable;
            r_out.sending_slot <= status.slot_index;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `MKR_ASSERT(a_result_follows, i_clk, i_rst_n, in_acc |=> r_out_valid)
    `MKR_ASSERT(a_gap_is_silent, i_clk, i_rst_n,
        tick && (status.slot_index >= SLOT_W'(NUM_SLOTS)) |=> !r_out.key_on)
    `MKR_ASSERT(a_bus_keeps_slot, i_clk, i_rst_n,
        in_acc && (i_in_data.operation != OP_TICK) |=> $stable(status.slot_index))
    `MKR_ASSERT(a_key_needs_enable, i_clk, i_rst_n,
        r_out_valid && r_out.key_on |-> r_enable)
    `MKR_ASSERT_NORST(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

FILE: rtl/mkr_sender.sv
module mkr_sender (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tick,
    input  logic [mkr_pkg::CODE_W-1:0]     i_code,
    output mkr_pkg::t_sender_status        o_status,
    output logic                           o_next_active
);
    import mkr_pkg::*;

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [ELEM_W-1:0] r_elem, n_elem;
    logic [SUB_W-1:0]  r_sub, n_sub;
    logic              r_active, n_active;

    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [BITS_W-1:0] bits;
    logic [LEN_W-1:0]  bit_idx;
    logic              in_range;
    logic              silent;
    logic              dash;
    logic [SUB_W-1:0]  sub_inc;
    logic              elem_step;
    logic [ELEM_W:0]   elem_wide;

    always_comb begin
        code      = (i_code > CODE_W'(MAX_CODE)) ? '0 : i_code;
        len       = sym_len(code);
        bits      = sym_bits(code);
        bit_idx   = len - r_elem;
        in_range  = (r_elem != '0) && (r_elem <= len);
        silent    = (code == '0) || !in_range;
        dash      = !silent && (((bits >> bit_idx) & BITS_W'(1)) != '0);
        sub_inc   = r_sub + SUB_W'(1);
        elem_step = 1'b0;

        n_slot   = r_slot;
        n_elem   = r_elem;
        n_sub    = r_sub;
        n_active = r_active;

        if (dash) begin
            n_active = (r_sub <= SUB_W'(3));
            if (sub_inc > SUB_W'(4)) begin
                elem_step = 1'b1;
            end
        end else begin
            n_active = (r_sub <= SUB_W'(1)) && !silent;
            if (sub_inc > SUB_W'(2)) begin
                elem_step = 1'b1;
            end
        end
        elem_wide = {1'b0, r_elem} + {{ELEM_W{1'b0}}, elem_step};

        if (i_tick) begin
            if (r_slot >= SLOT_W'(NUM_SLOTS)) begin
                n_active = 1'b0;
                if (r_elem >= ELEM_W'(GAP_UNITS)) begin
                    n_elem = ELEM_W'(1);
                    n_sub  = SUB_W'(1);
                    n_slot = '0;
                end else begin
                    n_elem = r_elem + ELEM_W'(1);
                end
            end else begin
                n_sub = elem_step ? SUB_W'(1) : sub_inc;
                if (elem_wide > {1'b0, len}) begin
                    n_slot = r_slot + SLOT_W'(1);
                    n_elem = ELEM_W'(1);
                end else begin
                    n_elem = elem_wide[ELEM_W-1:0];
                end
            end
        end else begin
            n_active = r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_elem   <= ELEM_W'(1);
            r_sub    <= SUB_W'(1);
            r_active <= 1'b0;
        end else begin
            r_slot   <= n_slot;
            r_elem   <= n_elem;
            r_sub    <= n_sub;
            r_active <= n_active;
        end
    end

    assign o_status.slot_index = r_slot;
    assign o_status.active     = r_active;
    assign o_next_active       = n_active;

endmodule

FILE: sim/tb_morse_keyer_with_slot_registers_top.sv
`timescale 1ns / 1ps

module tb_morse_keyer_with_slot_registers_top;
    import mkr_pkg::*;

    localparam logic [1:0] OP_IDLE = 2'd3;
    localparam int RANDOM_ITEMS = 1900;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in_item   i_in_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       i_out_stall = 1'b0;

    morse_keyer_with_slot_registers_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Element counts and dash patterns, first element in the top used bit.
    int         morse_len [0:MAX_CODE] = '{
        3, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5,
        2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2, 2, 3, 4, 4, 3, 3, 1, 3, 3, 3, 4, 4, 4
    };
    logic [4:0] morse_dashes [0:MAX_CODE] = '{
        5'h00, 5'h1F, 5'h0F, 5'h07, 5'h03, 5'h01, 5'h00, 5'h10, 5'h18, 5'h1C, 5'h1E,
        5'h01, 5'h08, 5'h0A, 5'h04, 5'h00, 5'h02, 5'h06, 5'h00, 5'h00, 5'h07, 5'h05,
        5'h04, 5'h03, 5'h02, 5'h07, 5'h06, 5'h0D, 5'h02, 5'h00, 5'h01, 5'h01, 5'h01,
        5'h03, 5'h09, 5'h0B, 5'h0C
    };

    int bus_phase;
    int picked_reg;
    int slot_code [NUM_SLOTS];
    bit key_enable;
    int slot_pos;
    int elem_pos;
    int unit_pos;
    bit key_active;

    t_out_item   expected_keys [$];
    int          errors = 0;
    bit          idle_on = 1'b1;
    int          burst_left = 0;
    int unsigned stall_count = 0;
    int          stall_mode = 0;

    function automatic t_out_item advance_keyer(input t_in_item item);
        t_out_item res;
        int        shown;
        int        code;
        int        len;
        bit        dash;
        bit        silent;
        shown = slot_pos;
        case (item.operation)
            OP_STOP: bus_phase = 0;
            OP_BYTE: begin
                if (bus_phase == 0) begin
                    picked_reg = (item.rx_byte > SEL_MAX) ? SEL_MAX : item.rx_byte;
                end else if (bus_phase == 1) begin
                    if (picked_reg < NUM_SLOTS) begin
                        slot_code[picked_reg] = (item.rx_byte > MAX_CODE) ? 0 : item.rx_byte;
                    end else if (picked_reg == REG_ENABLE) begin
                        key_enable = (item.rx_byte != 0);
                    end
                end
                if (bus_phase < 2) begin
                    bus_phase++;
                end
            end
            OP_TICK: begin
                if (slot_pos >= NUM_SLOTS) begin
                    key_active = 1'b0;
                    elem_pos++;
                    if (elem_pos > GAP_UNITS) begin
                        elem_pos = 1;
                        unit_pos = 1;
                        slot_pos = 0;
                    end
                end else begin
                    code = slot_code[slot_pos];
                    if (code > MAX_CODE) begin
                        code = 0;
                    end
                    len = morse_len[code];
                    silent = (code == 0) || (elem_pos > len) || (elem_pos == 0);
                    dash = 1'b0;
                    if (elem_pos >= 1 && elem_pos <= len) begin
                        dash = morse_dashes[code][len - elem_pos];
                    end
                    if (silent) begin
                        dash = 1'b0;
                    end
                    if (dash) begin
                        key_active = (unit_pos <= 3);
                        unit_pos++;
                        if (unit_pos > 4) begin
                            elem_pos++;
                            unit_pos = 1;
                        end
                    end else begin
                        key_active = (unit_pos <= 1) && !silent;
                        unit_pos++;
                        if (unit_pos > 2) begin
                            elem_pos++;
                            unit_pos = 1;
                        end
                    end
                    if (elem_pos > len) begin
                        slot_pos++;
                        elem_pos = 1;
                    end
                end
            end
            default: ;
        endcase
        res.key_on = key_active & key_enable;
        res.sending_slot = 4'(shown);
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_keys.push_back(advance_keyer(i_in_data));
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_keys.size() == 0) begin
                    $display("%t unexpected item: actual %p", $time, o_out_data);
                    errors++;
                end else begin
                    want = expected_keys.pop_front();
                    if (o_out_data.key_on !== want.key_on) begin
                        $display("%t key_on mismatch: expected %b actual %b",
                                 $time, want.key_on, o_out_data.key_on);
                        errors++;
                    end
                    if (o_out_data.sending_slot !== want.sending_slot) begin
                        $display("%t sending_slot mismatch: expected %0d actual %0d",
                                 $time, want.sending_slot, o_out_data.sending_slot);
                        errors++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        stall_count++;
        if (stall_count % 97 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= (stall_count % 3 == 0);
                default: i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] value);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle_on && gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= '{operation: op, rx_byte: value};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_register(input logic [7:0] index, input logic [7:0] value);
        send_item(OP_STOP, 8'h00);
        send_item(OP_BYTE, index);
        send_item(OP_BYTE, value);
    endtask

    task automatic test_slot_writes();
        write_register(8'd0, 8'(MAX_CODE));
        write_register(8'(REG_ENABLE), 8'd1);
        send_item(OP_BYTE, 8'hFF);
        write_register(8'(NUM_SLOTS - 1), 8'(MAX_CODE + 1));
    endtask

    task automatic test_code_change_midchar();
        repeat (4) send_item(OP_TICK, 8'h00);
        write_register(8'd0, 8'd15);
        repeat (2) send_item(OP_TICK, 8'hFF);
    endtask

    task automatic test_select_limits();
        write_register(8'hFF, 8'd5);
        write_register(8'(REG_ENABLE + 1), 8'h80);
    endtask

    task automatic test_unused_operation();
        send_item(OP_IDLE, 8'hFF);
        send_item(OP_IDLE, 8'h00);
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          pick;
        int          count;
        logic [7:0]  index;
        logic [7:0]  value;
        logic [1:0]  op;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = ((sent / 300) % 3) != 2;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                count = $urandom_range(1, 40);
                repeat (count) send_item(OP_TICK, 8'($urandom_range(0, 255)));
                sent += count;
            end else if (pick < 85) begin
                index = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, NUM_SLOTS));
                if (index == REG_ENABLE) begin
                    value = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                end else if ($urandom_range(0, 6) == 0) begin
                    value = 8'($urandom_range(0, 255));
                end else begin
                    value = 8'($urandom_range(0, MAX_CODE));
                end
                if ($urandom_range(0, 7) != 0) begin
                    send_item(OP_STOP, 8'($urandom_range(0, 255)));
                    sent++;
                end
                send_item(OP_BYTE, index);
                send_item(OP_BYTE, value);
                sent += 2;
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                end
            end else begin
                op = 2'($urandom_range(0, 3));
                send_item(op, 8'($urandom_range(0, 255)));
                if (op != OP_IDLE) begin
                    sent++;
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        bus_phase = 0;
        picked_reg = 0;
        foreach (slot_code[i]) begin
            slot_code[i] = 0;
        end
        key_enable = 1'b0;
        slot_pos = 0;
        elem_pos = 1;
        unit_pos = 1;
        key_active = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_slot_writes();
        test_code_change_midchar();
        test_select_limits();
        test_unused_operation();
        test_random_traffic();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_keys.size() == 0);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_keys.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/mkr_pkg.sv
rtl/mkr_sender.sv
rtl/morse_keyer_with_slot_registers_top.sv
sim/tb_morse_keyer_with_slot_registers_top.sv
